// ===== design/hsd_pkg.sv =====
// Shared types, constants and helper functions of the swing count handshake detector.
package hsd_pkg;

	localparam int unsigned POSE_W  = 32;
	localparam int unsigned FORCE_W = 24;
	localparam int unsigned THR_W   = 20;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned TIMER_W = 16;
	localparam int unsigned SQ_W    = 2 * FORCE_W - 1;
	localparam int unsigned SUM_W   = SQ_W + 1;
	localparam int unsigned DIST_W  = POSE_W + 1;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [TIMER_W-1:0] LONG_STILL_TICKS  = 16'd500;
	localparam logic [TIMER_W-1:0] SHORT_STILL_TICKS = 16'd50;
	localparam logic [SUM_W-1:0]   FORCE_SQ_LIMIT    = 48'd3146;
	localparam logic signed [FORCE_W-1:0] AXIS_FORCE_LIMIT = 24'sd102;

	localparam logic [THR_W-1:0] OUTWARD_RESET  = 20'd40000;
	localparam logic [THR_W-1:0] RETURN_RESET   = 20'd5000;
	localparam logic [CNT_W-1:0] REQUIRED_RESET = 8'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_OUTWARD_THRESHOLD = 8'd0;
	localparam cfg_idx_t CFG_RETURN_THRESHOLD  = 8'd1;
	localparam cfg_idx_t CFG_REQUIRED_SWINGS   = 8'd2;

	typedef struct packed {
		logic signed [POSE_W-1:0]  pose_z_um;
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		logic                      start_request;
		logic                      stop_request;
	} sample_t;

	typedef struct packed {
		logic signed [POSE_W-1:0] pose_z_um;
		logic                     start_request;
		logic                     stop_request;
		logic                     force_small;
		logic                     axes_below;
	} still_t;

	typedef struct packed {
		logic [THR_W-1:0] outward_threshold_um;
		logic [THR_W-1:0] return_threshold_um;
		logic [CNT_W-1:0] required_swings;
	} cfg_t;

	typedef struct packed {
		logic             handshake_done;
		logic [CNT_W-1:0] swing_total;
		logic             detecting;
		logic             swung_out;
	} result_t;

	function automatic logic [TIMER_W-1:0] timer_inc(input logic [TIMER_W-1:0] t);
		logic [TIMER_W-1:0] r;
		r = (t == '1) ? t : t + TIMER_W'(1);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (c == '1) ? c : c + CNT_W'(1);
		return r;
	endfunction

endpackage

// ===== design/hsd_force.sv =====
// Input register and force test pipeline: squares, sum and per-axis limit checks.
module hsd_force import hsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t in_item,
	output logic    out_valid,
	input  logic    out_ready,
	output still_t  out_item
);

	logic    valid_s1, valid_s2, valid_s3;
	logic    ready_s1, ready_s2, ready_s3;
	sample_t item_s1;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic signed [POSE_W-1:0] z_s2;
	logic    start_s2, stop_s2, axes_s2;
	still_t  item_s3;

	logic signed [2*FORCE_W-1:0] sqx, sqy, sqz;
	logic [SUM_W-1:0] sq_sum;
	logic axes_below;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign sqx = item_s1.force_x * item_s1.force_x;
	assign sqy = item_s1.force_y * item_s1.force_y;
	assign sqz = item_s1.force_z * item_s1.force_z;
	// Signed compare on purpose: any negative axis force passes.
	assign axes_below = (item_s1.force_x <= AXIS_FORCE_LIMIT) &&
	                    (item_s1.force_y <= AXIS_FORCE_LIMIT) &&
	                    (item_s1.force_z <= AXIS_FORCE_LIMIT);

	assign sq_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2} + {1'b0, sqz_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) item_s1 <= in_item;
		if (ready_s2 && valid_s1) begin
			sqx_s2   <= sqx[SQ_W-1:0];
			sqy_s2   <= sqy[SQ_W-1:0];
			sqz_s2   <= sqz[SQ_W-1:0];
			z_s2     <= item_s1.pose_z_um;
			start_s2 <= item_s1.start_request;
			stop_s2  <= item_s1.stop_request;
			axes_s2  <= axes_below;
		end
		if (ready_s3 && valid_s2) begin
			item_s3.pose_z_um     <= z_s2;
			item_s3.start_request <= start_s2;
			item_s3.stop_request  <= stop_s2;
			item_s3.force_small   <= sq_sum < FORCE_SQ_LIMIT;
			item_s3.axes_below    <= axes_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

// ===== design/hsd_track.sv =====
// Detector state, swing hysteresis, stillness timer and the result register.
module hsd_track import hsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  still_t  in_item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_item
);

	logic                     active_q, phase_q, ref_valid_q;
	logic [CNT_W-1:0]         count_q;
	logic [TIMER_W-1:0]       timer_q;
	logic signed [POSE_W-1:0] ref_z_q;
	logic                     res_valid_q;
	result_t                  res_q;

	logic                     fire, active_n, phase_n, enough, done, out_gt, ret_lt;
	logic [CNT_W-1:0]         count_n;
	logic [TIMER_W-1:0]       timer_n, timer_a;
	logic signed [POSE_W-1:0] ref_z;
	logic signed [DIST_W-1:0] diff;
	logic [DIST_W-1:0]        z_offset;

	assign in_ready = !res_valid_q || res_ready;
	assign fire     = in_valid && in_ready;

	always_comb begin
		ref_z    = ref_valid_q ? ref_z_q : in_item.pose_z_um;
		active_n = active_q || in_item.start_request;
		diff     = {in_item.pose_z_um[POSE_W-1], in_item.pose_z_um} - {ref_z[POSE_W-1], ref_z};
		z_offset = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
		out_gt   = z_offset > {{(DIST_W-THR_W){1'b0}}, cfg.outward_threshold_um};
		ret_lt   = z_offset < {{(DIST_W-THR_W){1'b0}}, cfg.return_threshold_um};

		phase_n = phase_q;
		count_n = count_q;
		timer_n = timer_q;
		enough  = 1'b0;
		done    = 1'b0;
		if (active_n) begin
			timer_a = in_item.force_small ? timer_inc(timer_q) : '0;
			phase_n = phase_q || out_gt;
			if (ret_lt && phase_n) begin
				phase_n = 1'b0;
				count_n = count_inc(count_q);
			end
			enough  = count_n >= cfg.required_swings;
			timer_n = timer_a;
			if (enough) begin
				timer_n = in_item.axes_below ? timer_inc(timer_a) : '0;
			end
			done = (timer_n > LONG_STILL_TICKS) || ((timer_n > SHORT_STILL_TICKS) && enough);
		end else begin
			timer_a = timer_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= 1'b0;
			ref_valid_q <= 1'b0;
			count_q     <= '0;
			timer_q     <= '0;
			ref_z_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_ready) res_valid_q <= in_valid;
			if (fire) begin
				if (in_item.stop_request) begin
					active_q    <= 1'b0;
					phase_q     <= 1'b0;
					ref_valid_q <= 1'b0;
					count_q     <= '0;
					timer_q     <= '0;
					ref_z_q     <= '0;
				end else begin
					active_q    <= active_n;
					phase_q     <= phase_n;
					ref_valid_q <= 1'b1;
					count_q     <= count_n;
					timer_q     <= timer_n;
					ref_z_q     <= ref_z;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.handshake_done <= done;
			res_q.swing_total    <= count_n;
			res_q.detecting      <= active_n;
			res_q.swung_out      <= phase_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// ===== design/swing_count_handshake_detector_top.sv =====
// Top level of the swing count handshake detector: ports, configuration registers, packing.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_axis_tvalid/tready      tdata: pose Z and three forces; tuser: flags
//  m_axis    out        m_axis_tvalid/tready      tdata: done, swing total, detecting, swung out
//  cfg       in         cfg_valid/cfg_ready       cfg_index selects the register, cfg_data value
//
// One sample is taken every cycle when the output side keeps up. A sample passes four
// registers: the input register, loaded at its transfer, the force squaring stage, the sum and
// limit stage, and the result register that is loaded together with the state update.
// Reset is asynchronous and active low; it clears the detector state and loads the default
// thresholds. A stalled output fills the pipeline bubbles first, so s_axis_tready only drops
// once every stage holds a sample. Configuration writes are always taken.
module swing_count_handshake_detector_top import hsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Fields from bit 0: pose_z_um[31:0], force_x[55:32], force_y[79:56], force_z[103:80].
	input  logic [103:0]         s_axis_tdata,
	// Fields from bit 0: start_request[0], stop_request[1].
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Fields from bit 0: handshake_done[0], swing_total[8:1], detecting[9], swung_out[10];
	// bits above are zero.
	output logic [15:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	sample_t sample;
	still_t  still;
	logic    still_valid, still_ready;
	result_t result;

	// Configuration registers; an index past the last register is taken and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outward_threshold_um <= OUTWARD_RESET;
			cfg_q.return_threshold_um  <= RETURN_RESET;
			cfg_q.required_swings      <= REQUIRED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OUTWARD_THRESHOLD: cfg_q.outward_threshold_um <= cfg_data;
				CFG_RETURN_THRESHOLD:  cfg_q.return_threshold_um  <= cfg_data;
				CFG_REQUIRED_SWINGS:   cfg_q.required_swings      <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the incoming transfer into named fields.
	assign sample.pose_z_um     = s_axis_tdata[31:0];
	assign sample.force_x       = s_axis_tdata[55:32];
	assign sample.force_y       = s_axis_tdata[79:56];
	assign sample.force_z       = s_axis_tdata[103:80];
	assign sample.start_request = s_axis_tuser[0];
	assign sample.stop_request  = s_axis_tuser[1];

	// The force tests depend on the sample alone, so they run ahead of the state update.
	hsd_force u_force (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (sample),
		.out_valid (still_valid),
		.out_ready (still_ready),
		.out_item  (still)
	);

	// The reference, swing phase, counter and timer all update in the final stage, so each
	// sample sees the state left by the one before it.
	hsd_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (still_valid),
		.in_ready  (still_ready),
		.in_item   (still),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_item  (result)
	);

	assign m_axis_tdata = {5'b0, result.swung_out, result.detecting, result.swing_total,
	                       result.handshake_done};

endmodule
